[hw/rtl/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define SBF7_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// checked on every rising edge, reset included
`define SBF7_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

[hw/rtl/sbf7_pkg.sv]
`timescale 1ns / 1ps

package sbf7_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 4096;
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int WIN        = 7;
    localparam int LINES      = WIN - 1;
    localparam int PIX_W      = 8;
    localparam int COLS_CFG_W = 11;
    localparam int ROWS_CFG_W = 13;
    localparam int CSUM_W     = 11;
    localparam int TOTAL_W    = 14;

    // config channel
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = CFG_IDX_W'(1);

    localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(512);
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(512);

    // rounded divide by 49 as multiply by reciprocal and shift
    localparam int WIN_AREA    = WIN * WIN;
    localparam int ROUND_BIAS  = (WIN_AREA - 1) / 2;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 15;
    localparam logic [RECIP_W-1:0] RECIP_AREA =
        RECIP_W'((2 ** RECIP_SHIFT + WIN_AREA - 1) / WIN_AREA);
    localparam int PROD_W      = TOTAL_W + RECIP_W;

    typedef logic [LINES*PIX_W-1:0] line_word_t;
    typedef logic [CSUM_W-1:0]      csum_t;
    typedef logic [TOTAL_W-1:0]     total_t;

endpackage

[hw/rtl/sbf7_if.sv]
`timescale 1ns / 1ps

interface sbf7_pixel_if;
    logic                       valid;
    logic                       ready;
    logic [sbf7_pkg::PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface sbf7_result_if;
    logic                       valid;
    logic                       ready;
    logic [sbf7_pkg::PIX_W-1:0] mean_value;
    logic                       window_full;
    logic                       frame_end;

    modport source (output valid, output mean_value, output window_full,
                    output frame_end, input ready);
    modport sink   (input valid, input mean_value, input window_full,
                    input frame_end, output ready);
endinterface

interface sbf7_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [sbf7_pkg::CFG_IDX_W-1:0]  index;
    logic [sbf7_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/sbf7_line_store.sv]
`timescale 1ns / 1ps

// six previous rows of one column packed in one word
module sbf7_line_store (
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [sbf7_pkg::COL_W-1:0]   rd_addr,
    output sbf7_pkg::line_word_t         rd_data,
    input  logic                         wr_en,
    input  logic [sbf7_pkg::COL_W-1:0]   wr_addr,
    input  sbf7_pkg::line_word_t         wr_data
);

    sbf7_pkg::line_word_t mem [sbf7_pkg::MAX_COLS];
    sbf7_pkg::line_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/sbf7_sum_cell.sv]
`timescale 1ns / 1ps

// one column sum of the window; passes it on and adds it to the running partial
module sbf7_sum_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               shift_en,
    input  sbf7_pkg::csum_t    value_in,
    input  sbf7_pkg::total_t   partial_in,
    output sbf7_pkg::csum_t    value_out,
    output sbf7_pkg::total_t   partial_out
);

    sbf7_pkg::csum_t value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (shift_en)
        begin
            value_reg <= value_in;
        end
    end

    assign value_out   = value_reg;
    assign partial_out = partial_in + sbf7_pkg::TOTAL_W'(value_reg);

endmodule

[hw/rtl/separable_box_filter_7x7_top.sv]
`timescale 1ns / 1ps

// 7x7 box mean over an 8-bit greyscale stream in raster order. one result
// transaction per pixel transaction, one pixel per clock sustained unless
// results stall: every stage is a single register step and the line store
// reads and writes once per pixel; stages 1-3 feed the output reg. the result
// carries the rounded mean of the window centred three rows and three columns
// back, window_full when that window lies inside the frame (mean reads 0
// otherwise) and frame_end on the frame's last pixel. frame_cols (index 0)
// and frame_rows (index 1) are clamped to 7..1024 and 7..4096 on write and
// should be changed only with the pipeline empty. the line store has no
// clearing pass after reset: the first six rows of a frame only fill it
module separable_box_filter_7x7_top (
    input  logic               clk,
    input  logic               rst_n,
    sbf7_pixel_if.sink         pixel_chan,
    sbf7_result_if.source      result_chan,
    sbf7_cfg_if.sink           cfg_chan
);

    typedef struct packed {
        logic full;
        logic frame_end;
    } flags_t;

    // ---------------------------------------------------------------
    // configuration, clamped on write
    // ---------------------------------------------------------------
    logic [sbf7_pkg::COLS_CFG_W-1:0] cols_reg, cols_next;
    logic [sbf7_pkg::ROWS_CFG_W-1:0] rows_reg, rows_next;
    logic [sbf7_pkg::COLS_CFG_W-1:0] cfg_cols;
    logic [sbf7_pkg::ROWS_CFG_W-1:0] cfg_rows;
    logic                            cfg_write;

    assign cfg_chan.ready = 1'b1;
    assign cfg_write      = cfg_chan.valid && cfg_chan.ready;
    assign cfg_cols       = cfg_chan.data[sbf7_pkg::COLS_CFG_W-1:0];
    assign cfg_rows       = cfg_chan.data[sbf7_pkg::ROWS_CFG_W-1:0];

    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_write)
        begin
            unique case (cfg_chan.index)
                sbf7_pkg::REG_FRAME_COLS:
                begin
                    if (cfg_cols < sbf7_pkg::COLS_CFG_W'(sbf7_pkg::WIN))
                        cols_next = sbf7_pkg::COLS_CFG_W'(sbf7_pkg::WIN);
                    else if (cfg_cols > sbf7_pkg::COLS_CFG_W'(sbf7_pkg::MAX_COLS))
                        cols_next = sbf7_pkg::COLS_CFG_W'(sbf7_pkg::MAX_COLS);
                    else
                        cols_next = cfg_cols;
                end
                sbf7_pkg::REG_FRAME_ROWS:
                begin
                    if (cfg_rows < sbf7_pkg::ROWS_CFG_W'(sbf7_pkg::WIN))
                        rows_next = sbf7_pkg::ROWS_CFG_W'(sbf7_pkg::WIN);
                    else if (cfg_rows > sbf7_pkg::ROWS_CFG_W'(sbf7_pkg::MAX_ROWS))
                        rows_next = sbf7_pkg::ROWS_CFG_W'(sbf7_pkg::MAX_ROWS);
                    else
                        rows_next = cfg_rows;
                end
                default:
                begin
                    // unknown index, write dropped
                    cols_next = cols_reg;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // pipeline handshake: each stage takes a new item when empty or
    // when its own item moves on in the same cycle
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy_out;
    logic in_acc, adv1;

    assign rdy_out = !out_valid_reg || result_chan.ready;
    assign rdy3    = !v3_reg || rdy_out;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;

    assign pixel_chan.ready = rdy1;
    assign in_acc           = pixel_chan.valid && rdy1;
    assign adv1             = v1_reg && rdy2;

    // ---------------------------------------------------------------
    // frame position, moves on with every accepted pixel
    // ---------------------------------------------------------------
    logic [sbf7_pkg::COL_W-1:0] col_reg, col_next;
    logic [sbf7_pkg::ROW_W-1:0] row_reg, row_next;
    logic                       last_col, last_row;
    flags_t                     flags_in;

    assign last_col = (sbf7_pkg::COLS_CFG_W'(col_reg) + 1'b1) >= cols_reg;
    assign last_row = (sbf7_pkg::ROWS_CFG_W'(row_reg) + 1'b1) >= rows_reg;

    assign flags_in.full      = (row_reg >= sbf7_pkg::ROW_W'(sbf7_pkg::LINES))
                             && (col_reg >= sbf7_pkg::COL_W'(sbf7_pkg::LINES));
    assign flags_in.frame_end = last_col && last_row;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_acc)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= sbf7_pkg::COLS_RESET;
            rows_reg <= sbf7_pkg::ROWS_RESET;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 1: line store word for this column arrives, vertical sum
    // ---------------------------------------------------------------
    logic [sbf7_pkg::PIX_W-1:0] px1_reg;
    logic [sbf7_pkg::COL_W-1:0] col1_reg;
    flags_t                     flags1_reg;
    sbf7_pkg::line_word_t       line_rd;
    sbf7_pkg::line_word_t       line_wr;
    sbf7_pkg::csum_t            colsum;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            px1_reg    <= pixel_chan.pixel;
            col1_reg   <= col_reg;
            flags1_reg <= flags_in;
        end
    end

    // read at accept, write back the shifted column when the item moves on;
    // the same column comes back no sooner than seven pixels later
    sbf7_line_store u_line_store (
        .clk     (clk),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .rd_data (line_rd),
        .wr_en   (adv1),
        .wr_addr (col1_reg),
        .wr_data (line_wr)
    );

    // oldest row drops out, this pixel becomes the newest stored row
    assign line_wr = {px1_reg, line_rd[sbf7_pkg::LINES*sbf7_pkg::PIX_W-1:sbf7_pkg::PIX_W]};

    always_comb
    begin
        colsum = sbf7_pkg::CSUM_W'(px1_reg);
        for (int k = 0; k < sbf7_pkg::LINES; k++)
        begin
            colsum = colsum + sbf7_pkg::CSUM_W'(line_rd[k*sbf7_pkg::PIX_W +: sbf7_pkg::PIX_W]);
        end
    end

    // ---------------------------------------------------------------
    // stage 2: chain of column-sum cells, newest at the top end
    // ---------------------------------------------------------------
    flags_t             flags2_reg;
    sbf7_pkg::csum_t    cell_value   [sbf7_pkg::WIN];
    sbf7_pkg::total_t   cell_partial [sbf7_pkg::WIN+1];
    sbf7_pkg::total_t   total;

    assign cell_partial[0] = '0;

    for (genvar k = 0; k < sbf7_pkg::WIN; k++)
    begin : g_cell
        sbf7_pkg::csum_t cell_in;

        if (k == sbf7_pkg::WIN - 1)
        begin : g_newest
            assign cell_in = colsum;
        end
        else
        begin : g_older
            assign cell_in = cell_value[k+1];
        end

        sbf7_sum_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .shift_en    (adv1),
            .value_in    (cell_in),
            .partial_in  (cell_partial[k]),
            .value_out   (cell_value[k]),
            .partial_out (cell_partial[k+1])
        );
    end

    assign total = cell_partial[sbf7_pkg::WIN];

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            flags2_reg <= flags1_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: biased 7x7 sum for the rounded divide
    // ---------------------------------------------------------------
    sbf7_pkg::total_t        sum3_reg;
    flags_t                  flags3_reg;
    logic [sbf7_pkg::PROD_W-1:0] prod;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            sum3_reg   <= total + sbf7_pkg::TOTAL_W'(sbf7_pkg::ROUND_BIAS);
            flags3_reg <= flags2_reg;
        end
    end

    // reciprocal multiply, exact over the whole sum range
    assign prod = sbf7_pkg::PROD_W'(sum3_reg) * sbf7_pkg::PROD_W'(sbf7_pkg::RECIP_AREA);

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    logic [sbf7_pkg::PIX_W-1:0] mean_reg;
    flags_t                     flags_out_reg;

    always_ff @(posedge clk)
    begin
        if (rdy_out)
        begin
            mean_reg      <= flags3_reg.full ? prod[sbf7_pkg::RECIP_SHIFT +: sbf7_pkg::PIX_W]
                                             : '0;
            flags_out_reg <= flags3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_acc;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy_out)
                out_valid_reg <= v3_reg;
        end
    end

    assign result_chan.valid       = out_valid_reg;
    assign result_chan.mean_value  = mean_reg;
    assign result_chan.window_full = flags_out_reg.full;
    assign result_chan.frame_end   = flags_out_reg.frame_end;

endmodule

[hw/rtl/sbf7_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbf7_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic [sbf7_pkg::PIX_W-1:0] mean_value,
    input logic                       window_full,
    input logic                       frame_end
);

    // a waiting result stays offered
    `SBF7_ASSERT_RST(a_res_hold, clk, rst_n, res_valid && !res_ready |=> res_valid, "result dropped while stalled")

    // the last pixel of a frame always has a full window
    `SBF7_ASSERT_RST(a_end_full, clk, rst_n, res_valid && frame_end |-> window_full, "frame end without full window")

    // border results read zero
    `SBF7_ASSERT_RST(a_border_zero, clk, rst_n, res_valid && !window_full |-> mean_value == '0, "border mean not zero")

    // with the output register free the pipeline can always take a pixel
    `SBF7_ASSERT_RST(a_ready_free, clk, rst_n, !res_valid |-> in_ready, "input stalled with empty output")

    // nothing is offered while in reset
    `SBF7_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> !res_valid, "result offered during reset")

endmodule

bind separable_box_filter_7x7_top sbf7_checker u_sbf7_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (pixel_chan.ready),
    .res_valid   (result_chan.valid),
    .res_ready   (result_chan.ready),
    .mean_value  (result_chan.mean_value),
    .window_full (result_chan.window_full),
    .frame_end   (result_chan.frame_end)
);
